// ===== rtl/fqdk_pkg.sv =====
// Package: widths, codes, record layout and controller/datapath interface types.
`default_nettype none
package fqdk_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int PID_W  = 22;
  localparam int PRIO_W = 8;
  localparam int RT_W   = 16;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int REC_W  = PID_W + PRIO_W + RT_W;
  localparam int DATA_W = ((REC_W + 7) / 8) * 8;

  // command codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // pid in the low bits, matching the word layout
  typedef struct packed {
    logic [RT_W-1:0]   runtime;
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0]  pid;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RES_NONE_OK,
    RES_EMPTY,
    RES_FULL,
    RES_REC
  } res_sel_t;

  typedef enum logic {
    RD_HEAD,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic     ld_in;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_push;
    logic     wr_shift;
    logic     idx_clr;
    logic     idx_inc;
    logic     cnt_dec;
    logic     head_inc;
    logic     res_ld;
    res_sel_t res_sel;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              full;
    logic              match;
    logic              idx_last;
    logic              out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/fqdk_dpath.sv =====
// Datapath: entry memory, head pointer, count, scan index, result and output registers.
`default_nettype none
module fqdk_dpath #(
  parameter int QUEUE_DEPTH = fqdk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  fqdk_pkg::cmd_t               cmd,
  output fqdk_pkg::sts_t               sts,
  input  wire [fqdk_pkg::DATA_W-1:0]   in_tdata,
  input  wire [fqdk_pkg::KIND_W-1:0]   in_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [fqdk_pkg::DATA_W-1:0]  out_tdata,
  output logic [fqdk_pkg::STAT_W-1:0]  out_tuser
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fqdk_pkg::rec_t mem [QUEUE_DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r;
  logic          out_valid_r, out_valid_nxt;

  logic [fqdk_pkg::KIND_W-1:0] kind_r;
  fqdk_pkg::rec_t              rec_in_r;
  fqdk_pkg::rec_t              rdata_r;
  fqdk_pkg::rec_t              res_rec_r, res_rec_nxt;
  logic [fqdk_pkg::STAT_W-1:0] res_st_r, res_st_nxt;
  fqdk_pkg::rec_t              out_rec_r;
  logic [fqdk_pkg::STAT_W-1:0] out_st_r;

  logic [AW-1:0] rd_addr, wr_addr, rd_off;
  logic [AW-1:0] idx_m1;

  // head + offset, modulo the depth (both operands below the depth)
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign idx_m1  = idx_r - AW'(1);
  assign rd_off  = (cmd.rd_sel == fqdk_pkg::RD_NEXT) ? (idx_r + AW'(1)) : '0;
  assign rd_addr = wrap_add(head_r, rd_off);
  assign wr_addr = cmd.wr_shift ? wrap_add(head_r, idx_m1) : wrap_add(head_r, cnt_r[AW-1:0]);

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_push) begin
      mem[wr_addr] <= rec_in_r;
    end else if (cmd.wr_shift) begin
      mem[wr_addr] <= rdata_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (cmd.head_inc) begin
      head_nxt = wrap_add(head_r, AW'(1));
    end
    if (cmd.wr_push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    res_st_nxt  = fqdk_pkg::ST_OK;
    res_rec_nxt = '0;
    case (cmd.res_sel)
      fqdk_pkg::RES_EMPTY: res_st_nxt = fqdk_pkg::ST_EMPTY;
      fqdk_pkg::RES_FULL:  res_st_nxt = fqdk_pkg::ST_FULL;
      fqdk_pkg::RES_REC:   res_rec_nxt = rdata_r;
      default:             res_st_nxt = fqdk_pkg::ST_OK;
    endcase
  end

  assign out_valid_nxt = cmd.out_ld | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      kind_r   <= in_tuser;
      rec_in_r <= in_tdata[fqdk_pkg::REC_W-1:0];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.res_ld) begin
      res_st_r  <= res_st_nxt;
      res_rec_r <= res_rec_nxt;
    end
    if (cmd.out_ld) begin
      out_st_r  <= res_st_r;
      out_rec_r <= res_rec_r;
    end
  end

  assign sts.kind     = kind_r;
  assign sts.empty    = (cnt_r == '0);
  assign sts.full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign sts.match    = (rdata_r.pid == rec_in_r.pid);
  assign sts.idx_last = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign sts.out_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{(fqdk_pkg::DATA_W - fqdk_pkg::REC_W){1'b0}}, out_rec_r};

endmodule
`default_nettype wire

// ===== rtl/fqdk_ctrl.sv =====
// Controller: command sequencing state machine.
`default_nettype none
module fqdk_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  output logic            in_tready,
  input  fqdk_pkg::sts_t  sts,
  output fqdk_pkg::cmd_t  cmd
);

  fqdk_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqdk_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.rd_sel  = fqdk_pkg::RD_HEAD;
    cmd.res_sel = fqdk_pkg::RES_NONE_OK;
    in_tready   = 1'b0;
    unique case (state_r)
      fqdk_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.ld_in  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = fqdk_pkg::S_DECODE;
        end
      end
      fqdk_pkg::S_DECODE: begin
        cmd.res_ld = 1'b1;
        state_nxt  = fqdk_pkg::S_EMIT;
        case (sts.kind)
          fqdk_pkg::KIND_PUSH: begin
            if (sts.full) begin
              cmd.res_sel = fqdk_pkg::RES_FULL;
            end else begin
              cmd.wr_push = 1'b1;
            end
          end
          fqdk_pkg::KIND_POP: begin
            if (sts.empty) begin
              cmd.res_sel = fqdk_pkg::RES_EMPTY;
            end else begin
              cmd.res_ld = 1'b0;
              cmd.rd_en  = 1'b1;
              state_nxt  = fqdk_pkg::S_POP;
            end
          end
          fqdk_pkg::KIND_DEL: begin
            if (sts.empty) begin
              cmd.res_sel = fqdk_pkg::RES_EMPTY;
            end else begin
              cmd.res_ld  = 1'b0;
              cmd.rd_en   = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = fqdk_pkg::S_SCAN;
            end
          end
          default: cmd.res_sel = fqdk_pkg::RES_NONE_OK;
        endcase
      end
      fqdk_pkg::S_POP: begin
        cmd.res_ld   = 1'b1;
        cmd.res_sel  = fqdk_pkg::RES_REC;
        cmd.head_inc = 1'b1;
        cmd.cnt_dec  = 1'b1;
        state_nxt    = fqdk_pkg::S_EMIT;
      end
      fqdk_pkg::S_SCAN: begin
        // read data holds the entry at the scan index
        if (sts.match) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = fqdk_pkg::RES_REC;
          if (sts.idx_last) begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = fqdk_pkg::S_EMIT;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = fqdk_pkg::RD_NEXT;
            cmd.idx_inc = 1'b1;
            state_nxt   = fqdk_pkg::S_SHIFT;
          end
        end else if (sts.idx_last) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = fqdk_pkg::RES_EMPTY;
          state_nxt   = fqdk_pkg::S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = fqdk_pkg::RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      fqdk_pkg::S_SHIFT: begin
        // move entry at index down one slot
        cmd.wr_shift = 1'b1;
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = fqdk_pkg::S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = fqdk_pkg::RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      fqdk_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = fqdk_pkg::S_IDLE;
        end
      end
      default: state_nxt = fqdk_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/fifo_queue_with_delete_by_key.sv =====
// Top level: bounded record queue with push, pop and delete-by-pid.
//
// Usage: one command word enters on the in_ channel and exactly one result
// word leaves on the out_ channel. Commands are push (append a record),
// pop (remove the oldest record) and delete (remove the oldest record with
// the given pid, keeping the order of the rest). Records live in a circular
// buffer memory with a head pointer and an entry count.
// From accept to out_tvalid, push, refused push, empty pop, empty delete
// and the unused code go through the decode and emit states; pop adds
// the pop state; delete on a non-empty queue adds the scan state and the
// shift state for a hit before the tail, since the scan reads one entry a
// cycle through the single memory read port and the compaction after a hit
// moves one entry a cycle, so every stored entry is read exactly once.
// One command is worked at a time; the next word is accepted the cycle after
// the result is loaded into the output register, even while it waits there.
// Reset empties the queue and drops any pending result; memory contents are
// not cleared and need not be, since only written entries are ever read.
// If the receiver stalls, the result holds in the output register and the
// controller waits with the following result until the register frees up.
`default_nettype none
module fifo_queue_with_delete_by_key #(
  parameter int QUEUE_DEPTH = fqdk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // pid_key [21:0], prio_in [29:22], runtime_in [45:30], zero [47:46]
  input  wire [fqdk_pkg::DATA_W-1:0]   in_tdata,
  // kind [1:0]
  input  wire [fqdk_pkg::KIND_W-1:0]   in_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // pid_out [21:0], prio_out [29:22], runtime_out [45:30], zero [47:46]
  output logic [fqdk_pkg::DATA_W-1:0]  out_tdata,
  // status [1:0]
  output logic [fqdk_pkg::STAT_W-1:0]  out_tuser
);

  fqdk_pkg::cmd_t cmd;
  fqdk_pkg::sts_t sts;

  fqdk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fqdk_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== tb/fifo_queue_with_delete_by_key_test.sv =====
// Testbench for the record queue: push, pop and delete-by-pid words checked against a predictor.
module fifo_queue_with_delete_by_key_test;
  import fqdk_pkg::*;

  // Code 3 on in_tuser is not a command; the block must answer ok with zeros.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1425;
  // Worst case is far below this: a delete on a full queue scans every entry,
  // plus random gaps on both sides and one long receiver hold-off.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLDOFF_CYCLES = 250;

  // One command word as offered on the in_ channel.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [RT_W-1:0]   runtime;
    bit                drain_first;  // hold this word back until all results are in
  } queue_cmd_t;

  // One result word as expected on the out_ channel.
  typedef struct {
    logic [STAT_W-1:0] status;
    rec_t              removed;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;

  // Stimulus waiting to be offered, and the word currently on the bus.
  queue_cmd_t cmd_backlog[$];
  queue_cmd_t offered_cmd;
  // Predictor state: records in arrival order, oldest at index 0.
  rec_t held_records[$];
  // Results predicted at accept time, oldest first.
  queue_result_t awaited_results[$];

  int words_accepted = 0;
  int results_seen = 0;
  int error_count = 0;
  int cycle_count = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  fifo_queue_with_delete_by_key #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one accepted command to the predicted queue and return its result.
  function automatic queue_result_t apply_queue_command(queue_cmd_t c);
    queue_result_t res;
    int hit;
    res.status = ST_OK;
    res.removed = '0;
    hit = -1;
    case (c.kind)
      KIND_PUSH: begin
        if (held_records.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_records.push_back('{runtime: c.runtime, prio: c.prio, pid: c.pid});
        end
      end
      KIND_POP: begin
        if (held_records.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed = held_records.pop_front();
        end
      end
      KIND_DEL: begin
        // oldest match wins; later records close up behind it
        for (int i = 0; i < held_records.size(); i++) begin
          if (hit < 0 && held_records[i].pid == c.pid) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed = held_records[hit];
          held_records.delete(hit);
        end
      end
      default: ;  // unused code: no effect, ok status
    endcase
    return res;
  endfunction

  function automatic queue_cmd_t make_cmd(logic [KIND_W-1:0] kind, logic [PID_W-1:0] pid,
                                          logic [PRIO_W-1:0] prio, logic [RT_W-1:0] runtime);
    queue_cmd_t c;
    c.kind = kind;
    c.pid = pid;
    c.prio = prio;
    c.runtime = runtime;
    c.drain_first = 1'b0;
    return c;
  endfunction

  // Driver: offers backlog words, predicts each word as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_queue_command(offered_cmd));
        words_accepted++;
      end
      // Only change the bus when nothing is pending or the pending word just went.
      if (!in_tvalid || in_tready) begin
        if (cmd_backlog.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (cmd_backlog[0].drain_first && awaited_results.size() != 0) begin
          in_tvalid <= 1'b0;
        end else if (!(words_accepted >= 500 && words_accepted < 800) &&
                     $urandom_range(99) < 24) begin
          in_tvalid <= 1'b0;
        end else begin
          offered_cmd = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= offered_cmd.kind;
          in_tdata <= {{(DATA_W-REC_W){1'b0}}, offered_cmd.runtime, offered_cmd.prio,
                       offered_cmd.pid};
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result word with no command outstanding: status %0d data %h",
                 out_tuser, out_tdata);
          error_count++;
        end else begin
          queue_result_t exp_res;
          rec_t got;
          exp_res = awaited_results.pop_front();
          got = out_tdata[REC_W-1:0];
          if (out_tuser !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_tuser);
            error_count++;
          end
          if (got.pid !== exp_res.removed.pid) begin
            $error("pid_out: expected %h, got %h", exp_res.removed.pid, got.pid);
            error_count++;
          end
          if (got.prio !== exp_res.removed.prio) begin
            $error("prio_out: expected %h, got %h", exp_res.removed.prio, got.prio);
            error_count++;
          end
          if (got.runtime !== exp_res.removed.runtime) begin
            $error("runtime_out: expected %h, got %h", exp_res.removed.runtime, got.runtime);
            error_count++;
          end
        end
      end
      // One long stall mid-run: the sender keeps offering, so the block backs up.
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else if (!holdoff_done && results_seen >= 1000) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        out_tready <= 1'b0;
      end else if (results_seen >= 500 && results_seen < 800) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int push_bias;
    int pick;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] recent_pids[$];
    queue_cmd_t c;

    // Directed: empty-queue cases first, then fill to full and carve out of the middle.
    cmd_backlog.push_back(make_cmd(KIND_POP, 22'h0, 8'h0, 16'h0));
    cmd_backlog.push_back(make_cmd(KIND_DEL, 22'h3FFFFF, 8'hFF, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(KIND_UNUSED, 22'h3FFFFF, 8'hFF, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(KIND_PUSH, 22'h0, 8'h0, 16'h0));
    cmd_backlog.push_back(make_cmd(KIND_PUSH, 22'h3FFFFF, 8'hFF, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(KIND_PUSH, 22'd5, 8'h11, 16'h1111));
    cmd_backlog.push_back(make_cmd(KIND_PUSH, 22'd5, 8'h22, 16'h2222));
    for (int i = 0; i < DEPTH - 4; i++) begin
      cmd_backlog.push_back(make_cmd(KIND_PUSH, PID_W'(22'h100 + i), 8'(8'h40 + i),
                                     16'(16'hA000 + i)));
    end
    // queue is full here
    cmd_backlog.push_back(make_cmd(KIND_PUSH, 22'h2AAAAA, 8'hAA, 16'hAAAA));
    cmd_backlog.push_back(make_cmd(KIND_DEL, 22'd5, 8'h0, 16'h0));  // duplicate pid: oldest goes
    cmd_backlog.push_back(make_cmd(KIND_DEL, 22'd12345, 8'h0, 16'h0));  // miss
    cmd_backlog.push_back(make_cmd(KIND_DEL, 22'h3FFFFF, 8'h0, 16'h0));
    // tail entry
    cmd_backlog.push_back(make_cmd(KIND_DEL, PID_W'(22'h100 + DEPTH - 5), 8'h0, 16'h0));
    cmd_backlog.push_back(make_cmd(KIND_POP, 22'h0, 8'h0, 16'h0));

    // Random: bursts that lean toward filling or draining, deletes mostly aimed at
    // recently pushed pids, small pids for duplicates, a little unused-code noise.
    push_bias = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        pick = $urandom_range(2);
        push_bias = (pick == 0) ? 80 : (pick == 1) ? 50 : 25;
      end
      pid = ($urandom_range(99) < 40) ? PID_W'($urandom_range(7)) : PID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 3) begin
        c = make_cmd(KIND_UNUSED, PID_W'($urandom), PRIO_W'($urandom), RT_W'($urandom));
      end else if (pick < push_bias) begin
        c = make_cmd(KIND_PUSH, pid, PRIO_W'($urandom), RT_W'($urandom));
        recent_pids.push_back(pid);
        if (recent_pids.size() > 32) void'(recent_pids.pop_front());
      end else if ($urandom_range(1) == 0) begin
        c = make_cmd(KIND_POP, PID_W'($urandom), PRIO_W'($urandom), RT_W'($urandom));
      end else begin
        if (recent_pids.size() != 0 && $urandom_range(99) < 75)
          pid = recent_pids[$urandom_range(recent_pids.size() - 1)];
        c = make_cmd(KIND_DEL, pid, PRIO_W'($urandom), RT_W'($urandom));
      end
      // a few points where the sender waits for the block to drain completely
      c.drain_first = (n == 300 || n == 700 || n == 1200);
      cmd_backlog.push_back(c);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // room for a stray extra word; a full-queue delete is the slowest command
    repeat (3 * DEPTH + 10) @(posedge clk);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fqdk_pkg.sv
rtl/fqdk_dpath.sv
rtl/fqdk_ctrl.sv
rtl/fifo_queue_with_delete_by_key.sv
tb/fifo_queue_with_delete_by_key_test.sv
